### rtl/core/elementwise_multi_input_combine_unit_assert.svh
// Assertion macros shared by the checkers of the element-wise combine unit.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ELEMENTWISE_MULTI_INPUT_COMBINE_UNIT_ASSERT_SVH
`define ELEMENTWISE_MULTI_INPUT_COMBINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define EWC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define EWC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is sampled high.
`define EWC_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ewc_pkg.sv
// Shared types, constants and helpers of the element-wise combine unit.
// No dependencies; the lane, product step, merge and top-level files import this package.
package ewc_pkg;

  localparam int DATA_W    = 32;
  localparam int COEF_W    = 16;
  localparam int WPROD_W   = DATA_W + COEF_W;
  localparam int FIELDS    = 4;
  localparam int ADDR_W    = 5;
  localparam int PROD_FRAC = 16;
  localparam int SUM_FRAC  = 12;
  localparam int CNT_W     = 3;

  localparam logic [CNT_W-1:0]         MIN_SOURCES        = 3'd2;
  localparam logic [CNT_W-1:0]         SOURCE_COUNT_RESET = 3'd2;
  localparam logic signed [COEF_W-1:0] COEF_ONE           = 16'sd4096;

  localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [1:0] {
    OP_PRODUCT = 2'd0,
    OP_SUM     = 2'd1,
    OP_MAX     = 2'd2,
    OP_MIN     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_OPERATION    = 3'd0,
    REG_SOURCE_COUNT = 3'd1,
    REG_COEF_0       = 3'd2,
    REG_COEF_1       = 3'd3,
    REG_COEF_2       = 3'd4,
    REG_COEF_3       = 3'd5
  } reg_idx_t;

  // What one lane hands to the merging stage.
  typedef struct packed {
    logic                      used;
    logic signed [WPROD_W-1:0] wprod;
    logic signed [DATA_W-1:0]  value;
  } lane_t;

  // A combined value together with its clamp flag.
  typedef struct packed {
    logic                     sat;
    logic signed [DATA_W-1:0] value;
  } res_t;

  function automatic res_t clamp32(input logic signed [63:0] v);
    res_t r;
    if (v > SAT_HI) begin
      r.sat   = 1'b1;
      r.value = SAT_HI[DATA_W-1:0];
    end else if (v < SAT_LO) begin
      r.sat   = 1'b1;
      r.value = SAT_LO[DATA_W-1:0];
    end else begin
      r.sat   = 1'b0;
      r.value = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/ewc_lane.sv
// One lane: registers its operand and the weighted product for sum mode.
// Depends on ewc_pkg.
module ewc_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic                                used,
  input  logic signed [ewc_pkg::DATA_W-1:0]   operand,
  input  logic signed [ewc_pkg::COEF_W-1:0]   coef,
  output ewc_pkg::lane_t                      lane
);
  import ewc_pkg::*;

  logic signed [WPROD_W-1:0] wprod_next;

  // An unused source contributes nothing to the sum.
  always_comb begin
    wprod_next = '0;
    if (used) wprod_next = operand * coef;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane.used  <= used;
      lane.wprod <= wprod_next;
      lane.value <= operand;
    end
  end

endmodule

### rtl/core/ewc_prod_step.sv
// One step of the product chain: a registered 32x32 multiply, then a
// registered floor shift and clamp. Depends on ewc_pkg.
module ewc_prod_step (
  input  logic                              clk,
  input  logic                              en,
  input  logic                              used,
  input  ewc_pkg::res_t                     acc_in,
  input  logic signed [ewc_pkg::DATA_W-1:0] operand,
  output ewc_pkg::res_t                     acc_out
);
  import ewc_pkg::*;

  logic signed [DATA_W-1:0]   acc_val;
  logic signed [2*DATA_W-1:0] prod;
  res_t                       acc_held;
  logic                       used_held;
  res_t                       scaled;

  assign acc_val = acc_in.value;

  always_ff @(posedge clk) begin
    if (en) begin
      prod      <= acc_val * operand;
      acc_held  <= acc_in;
      used_held <= used;
    end
  end

  assign scaled = clamp32(prod >>> PROD_FRAC);

  // A step beyond the active source count passes the running value through.
  always_ff @(posedge clk) begin
    if (en) begin
      if (used_held) begin
        acc_out.value <= scaled.value;
        acc_out.sat   <= acc_held.sat | scaled.sat;
      end else begin
        acc_out <= acc_held;
      end
    end
  end

endmodule

### rtl/core/ewc_merge.sv
// Merging stage: adds the weighted lane products and picks the maximum or
// minimum lane value, then scales and clamps the sum. Depends on ewc_pkg.
module ewc_merge #(
  parameter int LANES = 4
) (
  input  logic           clk,
  input  logic           en,
  input  ewc_pkg::op_t   op,
  input  ewc_pkg::lane_t lanes [LANES],
  output ewc_pkg::res_t  result
);
  import ewc_pkg::*;

  localparam int SUM_W = WPROD_W + $clog2(LANES);

  logic signed [SUM_W-1:0]  sum_next;
  logic signed [DATA_W-1:0] pick_next;
  logic signed [SUM_W-1:0]  sum;
  logic signed [DATA_W-1:0] pick;
  logic signed [63:0]       sum_wide;
  res_t                     sum_res;

  always_comb begin
    sum_next  = '0;
    pick_next = lanes[0].value;
    for (int i = 0; i < LANES; i++) begin
      sum_next = sum_next +
                 {{(SUM_W-WPROD_W){lanes[i].wprod[WPROD_W-1]}}, lanes[i].wprod};
    end
    for (int i = 1; i < LANES; i++) begin
      if (lanes[i].used) begin
        if (op == OP_MAX) begin
          if ($signed(lanes[i].value) > pick_next) pick_next = lanes[i].value;
        end else begin
          if ($signed(lanes[i].value) < pick_next) pick_next = lanes[i].value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum  <= sum_next;
      pick <= pick_next;
    end
  end

  // The Q22.28 sum goes back to Q16.16, rounding toward minus infinity.
  always_comb begin
    sum_wide = $signed({{(64-SUM_W){sum[SUM_W-1]}}, sum}) >>> SUM_FRAC;
    sum_res  = clamp32(sum_wide);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (op == OP_SUM) begin
        result <= sum_res;
      end else begin
        result.sat   <= 1'b0;
        result.value <= pick;
      end
    end
  end

endmodule

### rtl/core/elementwise_multi_input_combine_unit.sv
// Element-wise combine unit, top level: lanes, product chain, merge and
// output skid stage, plus the APB register file. Depends on ewc_pkg.
//
// Each input transaction on the s_ group carries one element from each of up
// to four source tensors; the unit returns one transaction on the m_ group
// with the product, weighted sum, maximum or minimum of the first
// source_count elements, source_count being held between two and the lane
// count. tlast travels with the element unchanged. Registers are written
// over the APB port only while no element is in flight; the user must keep
// to this, as the block itself does not enforce it. Throughput is one
// element per cycle while s_tready is high. Each product step is a multiply
// stage and a clamp stage, the chain having LANES - 1 steps, with LANES =
// min(MAX_SOURCES, 4). When m_tready is low the output register holds its
// transaction and one more result goes into a skid register; only then does
// s_tready drop and the whole pipeline wait. Synchronous reset empties the
// pipeline and the output side and loads the register defaults (weighted
// sum, two sources, unit weights).
module elementwise_multi_input_combine_unit #(
  parameter int MAX_SOURCES = 4
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // operand_0 [31:0], operand_1 [63:32], operand_2 [95:64], operand_3 [127:96]
  input  logic [ewc_pkg::FIELDS*ewc_pkg::DATA_W-1:0]    s_tdata,
  input  logic                                          s_tlast,
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // combined_value [31:0]
  output logic [ewc_pkg::DATA_W-1:0]                    m_tdata,
  // saturated [0]
  output logic                                          m_tuser,
  output logic                                          m_tlast,
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [ewc_pkg::ADDR_W-1:0]                    paddr,
  input  logic [31:0]                                   pwdata,
  output logic [31:0]                                   prdata,
  output logic                                          pready
);
  import ewc_pkg::*;

  localparam int LANES     = (MAX_SOURCES < FIELDS) ? MAX_SOURCES : FIELDS;
  localparam int PROD_LAT  = 2 * (LANES - 1);
  localparam int MERGE_LAT = 3;
  localparam int DEPTH     = (PROD_LAT > MERGE_LAT) ? PROD_LAT : MERGE_LAT;

  // Register file.
  op_t                      operation;
  logic [CNT_W-1:0]         source_count;
  logic signed [COEF_W-1:0] coef [FIELDS];
  logic                     wr_en;
  reg_idx_t                 reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      operation    <= OP_SUM;
      source_count <= SOURCE_COUNT_RESET;
      for (int i = 0; i < FIELDS; i++) coef[i] <= COEF_ONE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_OPERATION:    operation    <= op_t'(pwdata[1:0]);
        REG_SOURCE_COUNT: source_count <= pwdata[CNT_W-1:0];
        REG_COEF_0:       coef[0]      <= pwdata[COEF_W-1:0];
        REG_COEF_1:       coef[1]      <= pwdata[COEF_W-1:0];
        REG_COEF_2:       coef[2]      <= pwdata[COEF_W-1:0];
        REG_COEF_3:       coef[3]      <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OPERATION:    prdata = {30'd0, operation};
      REG_SOURCE_COUNT: prdata = {{(32-CNT_W){1'b0}}, source_count};
      REG_COEF_0:       prdata = {16'd0, coef[0]};
      REG_COEF_1:       prdata = {16'd0, coef[1]};
      REG_COEF_2:       prdata = {16'd0, coef[2]};
      REG_COEF_3:       prdata = {16'd0, coef[3]};
      default:          prdata = '0;
    endcase
  end

  // Active source count, held between two and the number of lanes.
  logic [CNT_W-1:0] n_eff;
  logic             used [LANES];

  always_comb begin
    if (source_count < MIN_SOURCES) begin
      n_eff = MIN_SOURCES;
    end else if (source_count > CNT_W'(LANES)) begin
      n_eff = CNT_W'(LANES);
    end else begin
      n_eff = source_count;
    end
  end

  // Pipeline control.
  logic skid_valid;
  logic en;
  logic take;

  assign en       = ~skid_valid;
  assign s_tready = ~skid_valid;
  assign take     = s_tvalid & s_tready;

  logic signed [DATA_W-1:0] operand [LANES];
  lane_t                    lane_q  [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign operand[i] = s_tdata[i*DATA_W +: DATA_W];
    assign used[i]    = CNT_W'(i) < n_eff;

    ewc_lane u_lane (
      .clk     (clk),
      .en      (en),
      .used    (used[i]),
      .operand (operand[i]),
      .coef    (coef[i]),
      .lane    (lane_q[i])
    );
  end

  res_t merge_res;

  ewc_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk    (clk),
    .en     (en),
    .op     (operation),
    .lanes  (lane_q),
    .result (merge_res)
  );

  // Product chain; operand k is delayed by two registers for every step before it.
  res_t                     chain  [LANES];
  logic signed [DATA_W-1:0] step_x [1:LANES-1];

  assign chain[0].sat   = 1'b0;
  assign chain[0].value = operand[0];

  for (genvar k = 1; k < LANES; k++) begin : g_step
    if (k == 1) begin : g_direct
      assign step_x[k] = operand[k];
    end else begin : g_delay
      logic signed [DATA_W-1:0] xd [2*(k-1)];
      always_ff @(posedge clk) begin
        if (en) begin
          xd[0] <= operand[k];
          for (int j = 1; j < 2*(k-1); j++) xd[j] <= xd[j-1];
        end
      end
      assign step_x[k] = xd[2*(k-1)-1];
    end

    ewc_prod_step u_step (
      .clk     (clk),
      .en      (en),
      .used    (used[k]),
      .acc_in  (chain[k-1]),
      .operand (step_x[k]),
      .acc_out (chain[k])
    );
  end

  // Bring both result paths to the same depth.
  res_t prod_al;
  res_t merge_al;

  if (DEPTH > PROD_LAT) begin : g_prod_al
    res_t pd [DEPTH-PROD_LAT];
    always_ff @(posedge clk) begin
      if (en) begin
        pd[0] <= chain[LANES-1];
        for (int j = 1; j < DEPTH-PROD_LAT; j++) pd[j] <= pd[j-1];
      end
    end
    assign prod_al = pd[DEPTH-PROD_LAT-1];
  end else begin : g_prod_direct
    assign prod_al = chain[LANES-1];
  end

  if (DEPTH > MERGE_LAT) begin : g_merge_al
    res_t md [DEPTH-MERGE_LAT];
    always_ff @(posedge clk) begin
      if (en) begin
        md[0] <= merge_res;
        for (int j = 1; j < DEPTH-MERGE_LAT; j++) md[j] <= md[j-1];
      end
    end
    assign merge_al = md[DEPTH-MERGE_LAT-1];
  end else begin : g_merge_direct
    assign merge_al = merge_res;
  end

  logic vld [DEPTH];
  logic lst [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DEPTH; j++) vld[j] <= 1'b0;
    end else if (en) begin
      vld[0] <= take;
      for (int j = 1; j < DEPTH; j++) vld[j] <= vld[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lst[0] <= s_tlast;
      for (int j = 1; j < DEPTH; j++) lst[j] <= lst[j-1];
    end
  end

  logic pipe_valid;
  logic pipe_last;
  res_t pipe_res;

  assign pipe_valid = vld[DEPTH-1];
  assign pipe_last  = lst[DEPTH-1];
  assign pipe_res   = (operation == OP_PRODUCT) ? prod_al : merge_al;

  // Output register with a one-entry skid behind it.
  res_t out_res;
  logic out_last;
  res_t skid_res;
  logic skid_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= pipe_valid;
    end else if (pipe_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) begin
        out_res  <= skid_res;
        out_last <= skid_last;
      end
    end else if (!m_tvalid || m_tready) begin
      out_res  <= pipe_res;
      out_last <= pipe_last;
    end else begin
      skid_res  <= pipe_res;
      skid_last <= pipe_last;
    end
  end

  assign m_tdata = out_res.value;
  assign m_tuser = out_res.sat;
  assign m_tlast = out_last;

endmodule

### rtl/core/ewc_checker.sv
// Port-level checks of the element-wise combine unit, bound to its top level.
// Depends on elementwise_multi_input_combine_unit_assert.svh.
`include "elementwise_multi_input_combine_unit_assert.svh"

module ewc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // A stalled result transaction keeps its payload.
  `EWC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output changed while stalled")

  // Input backpressure only appears while a result is waiting at the output.
  `EWC_ASSERT_IMP(a_stall_cause, !s_tready, m_tvalid, "s_tready low with empty output")

  // The skid register fills only on a cycle where the receiver refused a result.
  `EWC_ASSERT_IMP(a_fill_cause, $fell(s_tready), $past(m_tvalid && !m_tready), "s_tready fell without an output stall")

  // Reset leaves the output empty and the input open.
  `EWC_ASSERT_RST(a_reset_empty, !m_tvalid && s_tready, "block not empty after reset")

endmodule

bind elementwise_multi_input_combine_unit ewc_checker u_ewc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
